### hdl/shbs_pkg.sv
package shbs_pkg;

	typedef struct packed {
		logic [7:0] msg_byte;
		logic       has_byte;
		logic       end_of_msg;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_RUN,
		ST_FOLD,
		ST_EMIT
	} state_t;

	// Control from the sequencer to the round unit.
	typedef struct packed {
		logic       load;
		logic       step;
		logic [5:0] rnd;
	} rnd_ctl_t;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage

### hdl/shbs_round.sv
module shbs_round
	import shbs_pkg::*;
(
	input  logic          clk,
	input  rnd_ctl_t      ctl,
	input  logic [31:0]   blk [16],
	input  logic [31:0]   chain [8],
	output logic [31:0]   work [8]
);

	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] wt, wn, x1, x14, s0, s1, t1, t2, e1, e0, ch, mj;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	// Message schedule runs in a 16-word window: w_q[0] is the current word and
	// wn is the schedule word sixteen rounds ahead.
	always_comb begin
		x1  = w_q[1];
		x14 = w_q[14];
		s0  = rotr(x1, 7) ^ rotr(x1, 18) ^ (x1 >> 3);
		s1  = rotr(x14, 17) ^ rotr(x14, 19) ^ (x14 >> 10);
		wt  = w_q[0];
		wn  = w_q[0] + s0 + w_q[9] + s1;
		e1  = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		e0  = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		mj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1  = v_q[7] + e1 + ch + RK[ctl.rnd] + wt;
		t2  = e0 + mj;
	end

	// With ctl.step high, one round per cycle; the window rotates so the next word sits at index 0.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			w_q <= blk;
			v_q <= chain;
		end else if (ctl.step) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wn;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	assign work = v_q;

endmodule

### hdl/sha256_byte_stream_hasher_unit.sv
// SHA-256 hasher fed one byte per transfer on the input channel (in, in_valid,
// in_stall). Fields: msg_byte, has_byte, end_of_msg. Bytes are packed big-endian.
// A transfer with end_of_msg closes the message (its byte, if any, comes first);
// an end transfer with no byte and no bytes before it hashes the empty message.
// The 64th byte of a block starts a compression: a load, 64 rounds on the shared
// round unit and a fold, during all of which in_stall is high.
// At end of message one or two padding blocks are compressed and the digest
// leaves on the output channel (out, out_valid, out_stall) as eight transfers,
// word 0 first, last_word on word 7.
// Every digest word is held while out_stall is high; no input is taken until
// all eight are transferred.
// Reset (arst_n low) loads the initial hash words and clears the byte count.
module sha256_byte_stream_hasher_unit
	import shbs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in,
	input  logic      in_valid,
	output logic      in_stall,
	output out_item_t out,
	output logic      out_valid,
	input  logic      out_stall
);

	state_t      state_q, state_d;
	logic [31:0] chain_q [8];
	logic [31:0] blk_q [16];
	logic [31:0] work [8];
	logic [60:0] cnt_q;
	logic [5:0]  rnd_q;
	logic [2:0]  idx_q;
	logic        final_q;
	logic        second_q;
	rnd_ctl_t    ctl;
	logic        in_fire, out_fire;
	logic [5:0]  pos;
	logic [63:0] bits;

	assign in_fire  = in_valid && !in_stall;
	assign out_fire = out_valid && !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign pos      = cnt_q[5:0];
	assign bits     = {cnt_q, 3'b000};

	shbs_round u_round (
		.clk   (clk),
		.ctl   (ctl),
		.blk   (blk_q),
		.chain (chain_q),
		.work  (work)
	);

	// Sequencer next state and round unit control.
	always_comb begin
		state_d  = state_q;
		ctl.load = 1'b0;
		ctl.step = 1'b0;
		ctl.rnd  = rnd_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if ((in.has_byte && pos == 6'd63) || in.end_of_msg) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				state_d  = ST_RUN;
				ctl.load = 1'b1;
			end
			ST_RUN: begin
				ctl.step = 1'b1;
				if (rnd_q == 6'd63) state_d = ST_FOLD;
			end
			ST_FOLD: begin
				if (final_q) begin
					state_d = second_q ? ST_PAD : ST_EMIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_fire && idx_q == 3'd7) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control counters, chain value and message length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q    <= '0;
			idx_q    <= '0;
			final_q  <= 1'b0;
			second_q <= 1'b0;
			cnt_q    <= '0;
			chain_q  <= IV;
		end else begin
			if (state_q == ST_RUN) rnd_q <= rnd_q + 6'd1;
			if (in_fire) begin
				if (in.has_byte) cnt_q <= cnt_q + 61'd1;
				final_q <= in.end_of_msg;
				// A second block is needed when the pad byte lands past offset 55,
				// or when the closing byte fills the block.
				if (in.has_byte) second_q <= (pos >= 6'd55);
				else second_q <= (pos >= 6'd56);
			end
			if (state_q == ST_FOLD) begin
				for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + work[i];
				if (second_q) second_q <= 1'b0;
			end
			if (out_fire) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == 3'd7) begin
					chain_q <= IV;
					cnt_q   <= '0;
					final_q <= 1'b0;
				end
			end
		end
	end

	// Block buffer: byte packing, padding and the length field.
	always_ff @(posedge clk) begin
		logic [31:0] nb [16];
		logic [5:0]  p;
		logic [4:0]  w;
		logic [63:0] len;
		nb = blk_q;
		p = pos;
		len = {cnt_q, 3'b000} + (in.has_byte ? 64'd8 : 64'd0);
		if (in_fire) begin
			if (in.has_byte) begin
				if (p[1:0] == 2'd0) nb[p[5:2]] = {in.msg_byte, 24'd0};
				else nb[p[5:2]][(5'd3 - {3'd0, p[1:0]}) * 8 +: 8] = in.msg_byte;
				p = p + 6'd1;
			end
			// A full block is compressed first; padding then follows in ST_FOLD.
			if (in.end_of_msg && !(in.has_byte && pos == 6'd63)) begin
				if (p[1:0] == 2'd0) nb[p[5:2]] = {PAD_BYTE, 24'd0};
				else nb[p[5:2]][(5'd3 - {3'd0, p[1:0]}) * 8 +: 8] = PAD_BYTE;
				for (int i = 0; i < 16; i++) begin
					w = 5'(i);
					if (w > {1'b0, p[5:2]}) nb[i] = 32'd0;
				end
				if (p < 6'd56) begin
					nb[14] = len[63:32];
					nb[15] = len[31:0];
				end
			end
		end else if (state_q == ST_FOLD && final_q && second_q) begin
			// Second final block: the length block after an overflowing pad, or
			// the pad-and-length block after a message that filled its block.
			for (int i = 0; i < 16; i++) nb[i] = 32'd0;
			if (pos == 6'd0) nb[0] = {PAD_BYTE, 24'd0};
			nb[14] = bits[63:32];
			nb[15] = bits[31:0];
		end
		blk_q <= nb;
	end

	assign out_valid        = (state_q == ST_EMIT);
	assign out.digest_word  = chain_q[idx_q];
	assign out.word_index   = idx_q;
	assign out.last_word    = (idx_q == 3'd7);

`ifndef SYNTHESIS
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_fire) else $error("input taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(idx_q)))
		else $error("digest word dropped");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && out.last_word) |=> (state_q == ST_IDLE && cnt_q == 61'd0))
		else $error("no rearm after digest");
`endif

endmodule

### tb/sv/tb_top.sv
module tb_top
	import shbs_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	logic      clk;
	logic      arst_n;
	in_item_t  in;
	logic      in_valid;
	logic      in_stall;
	out_item_t out;
	logic      out_valid;
	logic      out_stall;

	sha256_byte_stream_hasher_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in       (in),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out      (out),
		.out_valid(out_valid),
		.out_stall(out_stall)
	);

	// Predictor state: the running hash of the message being fed.
	logic [31:0] hash_state [8];
	logic [31:0] msg_block [16];
	logic [60:0] byte_count;
	out_item_t   digest_q [$];

	int error_count;
	int words_seen;
	int messages_sent;
	bit quiet_tail;

	function automatic logic [31:0] rotr(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// One 64-round compression of msg_block into hash_state.
	task automatic compress_msg_block();
		logic [31:0] w [16];
		logic [31:0] v [8];
		logic [31:0] wt, s0, s1, t1, t2, x1, x14;
		for (int i = 0; i < 16; i++) w[i] = msg_block[i];
		for (int i = 0; i < 8; i++) v[i] = hash_state[i];
		for (int r = 0; r < 64; r++) begin
			if (r < 16) begin
				wt = w[r];
			end else begin
				x1 = w[(r + 1) & 15];
				x14 = w[(r + 14) & 15];
				s0 = rotr(x1, 7) ^ rotr(x1, 18) ^ (x1 >> 3);
				s1 = rotr(x14, 17) ^ rotr(x14, 19) ^ (x14 >> 10);
				wt = w[r & 15] + s0 + w[(r + 9) & 15] + s1;
				w[r & 15] = wt;
			end
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[r] + wt;
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_state[i] += v[i];
	endtask

	task automatic place_byte(int pos, logic [7:0] b);
		int wi;
		int sh;
		wi = (pos >> 2) & 15;
		sh = (3 - (pos & 3)) * 8;
		if ((pos & 3) == 0) msg_block[wi] = '0;
		msg_block[wi] |= 32'(b) << sh;
	endtask

	task automatic restart_hash();
		for (int i = 0; i < 8; i++) hash_state[i] = IV[i];
		byte_count = '0;
	endtask

	// Advance the predicted hash by one accepted transfer.
	task automatic hash_transfer(in_item_t it);
		int pos;
		logic [63:0] bits;
		out_item_t o;
		if (it.has_byte) begin
			pos = int'(byte_count[5:0]);
			place_byte(pos, it.msg_byte);
			byte_count = byte_count + 1'b1;
			if (pos == 63) compress_msg_block();
		end
		if (!it.end_of_msg) return;
		pos = int'(byte_count[5:0]);
		place_byte(pos, PAD_BYTE);
		for (int i = (pos >> 2) + 1; i < 16; i++) msg_block[i] = '0;
		if (pos + 1 > 56) begin
			compress_msg_block();
			for (int i = 0; i < 16; i++) msg_block[i] = '0;
		end
		bits = {byte_count, 3'b000};
		msg_block[14] = bits[63:32];
		msg_block[15] = bits[31:0];
		compress_msg_block();
		for (int i = 0; i < 8; i++) begin
			o.digest_word = hash_state[i];
			o.word_index = 3'(i);
			o.last_word = (i == 7);
			digest_q.push_back(o);
		end
		messages_sent++;
		restart_hash();
	endtask

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Digest check: compare every output transfer with the oldest expected word.
	always @(posedge clk) begin
		out_item_t exp_w;
		if (arst_n && out_valid && !out_stall) begin
			words_seen++;
			if (digest_q.size() == 0) begin
				$display("%0t: unexpected digest word %h idx %0d last %0b", $time,
					out.digest_word, out.word_index, out.last_word);
				error_count++;
			end else begin
				exp_w = digest_q.pop_front();
				if (out.digest_word !== exp_w.digest_word)
					$display("%0t: digest_word expected %h actual %h", $time,
						exp_w.digest_word, out.digest_word);
				if (out.word_index !== exp_w.word_index)
					$display("%0t: word_index expected %0d actual %0d", $time,
						exp_w.word_index, out.word_index);
				if (out.last_word !== exp_w.last_word)
					$display("%0t: last_word expected %0b actual %0b", $time,
						exp_w.last_word, out.last_word);
				if (out !== exp_w) error_count++;
			end
		end
	end

	// Receiver stall: random bursts, none in the quiet tail.
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet_tail && $urandom_range(0, 9) < 2) begin
				n = $urandom_range(1, 13);
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Send one transfer, with an optional idle burst ahead of it.
	task automatic send_item(in_item_t it);
		int n;
		if (!quiet_tail && $urandom_range(0, 9) < 2) begin
			n = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		in <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		hash_transfer(it);
		@(negedge clk);
	endtask

	function automatic in_item_t make_item(logic [7:0] b, logic h, logic e);
		in_item_t it;
		it.msg_byte = b;
		it.has_byte = h;
		it.end_of_msg = e;
		return it;
	endfunction

	// Directed rows: byte, has_byte, end_of_msg.
	localparam int NDIR = 12;
	localparam logic [9:0] DIR_ROWS [NDIR] = '{
		{8'h00, 1'b0, 1'b1},  // empty message
		{8'hff, 1'b0, 1'b0},  // nothing, byte ignored
		{8'h61, 1'b1, 1'b0},  // "abc"
		{8'h62, 1'b1, 1'b0},
		{8'h63, 1'b1, 1'b0},
		{8'h00, 1'b0, 1'b1},
		{8'hff, 1'b1, 1'b1},  // byte carried on the end transfer
		{8'h00, 1'b1, 1'b1},
		{8'h5a, 1'b0, 1'b0},
		{8'ha5, 1'b0, 1'b1},  // empty message again, byte ignored
		{8'h00, 1'b0, 1'b0},
		{8'h80, 1'b1, 1'b1}
	};

	// Send a whole message of the given length with random bytes.
	task automatic send_message(int len, bit end_with_byte);
		int body;
		body = end_with_byte && len > 0 ? len - 1 : len;
		for (int i = 0; i < body; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_item(make_item(8'($urandom), 1'b0, 1'b0));
			send_item(make_item(8'($urandom), 1'b1, 1'b0));
		end
		if (end_with_byte && len > 0)
			send_item(make_item(8'($urandom), 1'b1, 1'b1));
		else
			send_item(make_item(8'($urandom), 1'b0, 1'b1));
	endtask

	initial begin
		int sent;
		int len;
		error_count = 0;
		words_seen = 0;
		messages_sent = 0;
		quiet_tail = 0;
		restart_hash();
		for (int i = 0; i < 16; i++) msg_block[i] = '0;
		arst_n = 1'b0;
		in = '0;
		in_valid = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed rows; the digests of the empty message and "abc" are checked against known values.
		for (int r = 0; r < NDIR; r++) begin
			send_item(make_item(DIR_ROWS[r][9:2], DIR_ROWS[r][1], DIR_ROWS[r][0]));
			if (r == 0 && digest_q.size() == 8 && (digest_q[0].digest_word !== 32'he3b0c442
				|| digest_q[7].digest_word !== 32'h7852b855)) begin
				$display("%0t: empty digest expected e3b0c442..7852b855 actual %h..%h",
					$time, digest_q[0].digest_word, digest_q[7].digest_word);
				error_count++;
			end
			if (r == 5 && digest_q.size() == 8 && (digest_q[0].digest_word !== 32'hba7816bf
				|| digest_q[7].digest_word !== 32'hf20015ad)) begin
				$display("%0t: abc digest expected ba7816bf..f20015ad actual %h..%h",
					$time, digest_q[0].digest_word, digest_q[7].digest_word);
				error_count++;
			end
		end

		// Lengths around the padding boundaries.
		send_message(55, 1);
		send_message(56, 0);
		send_message(64, 1);
		sent = 55 + 57 + 64 + NDIR;

		// Random messages, mostly short, with the quiet tail at the end.
		while (sent < 410) begin
			if (sent > 340) quiet_tail = 1;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 12);
			send_message(len, $urandom_range(0, 1));
			sent += len + 1;
		end
		in_valid <= 1'b0;
		quiet_tail = 1;

		while (digest_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Hashed %0d messages, %0d digest words checked, with padding edges.",
			messages_sent, words_seen);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#5ms;
		$display("Timeout waiting for digest transfers.");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
